/* hw/rtl/hsv_pkg.sv */
// Shared types and constants of the HSV to RGB converter.
// Holds the request and response payload structs, the sector codes and the
// reciprocal constants used for division by constants; depends on nothing.
`timescale 1ns / 1ps

package hsv_pkg;

   localparam int unsigned HUE_W    = 15;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned QUOT_W   = 10;
   localparam int unsigned Q6_W     = 7;
   localparam int unsigned SECTOR_W = 3;

   // Division of a 13-bit value by 15 as (y * 8739) >> 17.
   localparam int unsigned          DIV60_IN_W    = 13;
   localparam int unsigned          RECIP60_W     = 14;
   localparam int unsigned          RECIP60_SHIFT = 17;
   localparam logic [RECIP60_W-1:0] RECIP60_MULT  = 14'd8739;

   // Division of a 10-bit value by 6 as (q * 1366) >> 13.
   localparam int unsigned         RECIP6_W     = 11;
   localparam int unsigned         RECIP6_SHIFT = 13;
   localparam logic [RECIP6_W-1:0] RECIP6_MULT  = 11'd1366;
   localparam logic [2:0]          SECTOR_COUNT = 3'd6;

   // Division of a 20-bit value by 3825 as (y * 1122868) >> 32.
   localparam int unsigned            DIV_IN_W       = 20;
   localparam int unsigned            RECIP3825_W    = 21;
   localparam int unsigned            RECIP3825_SHIFT = 32;
   localparam logic [RECIP3825_W-1:0] RECIP3825_MULT = 21'd1122868;

   typedef enum logic [SECTOR_W-1:0] {
      SEC_RED_YELLOW     = 3'd0,
      SEC_YELLOW_GREEN   = 3'd1,
      SEC_GREEN_CYAN     = 3'd2,
      SEC_CYAN_BLUE      = 3'd3,
      SEC_BLUE_MAGENTA   = 3'd4,
      SEC_MAGENTA_RED    = 3'd5
   } sector_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [BYTE_W-1:0] saturation;
      logic [BYTE_W-1:0] brightness;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } rsp_payload_type;

endpackage

/* hw/rtl/hsv_hue_split.sv */
// First two pipeline stages: splits the hue into sector quotient and fraction.
// Also forms the brightness times (255 - saturation) product; uses hsv_pkg.
`timescale 1ns / 1ps

module hsv_hue_split #(
   parameter int unsigned HUE_FRACTION_BITS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  hsv_pkg::req_payload_type           in_payload,
   output logic                               out_valid,
   output logic [hsv_pkg::QUOT_W-1:0]         out_quot,
   output logic [hsv_pkg::Q6_W-1:0]           out_quot6,
   output logic [HUE_FRACTION_BITS+5:0]       out_frac,
   output logic [hsv_pkg::BYTE_W-1:0]         out_sat,
   output logic [hsv_pkg::BYTE_W-1:0]         out_val,
   output logic [2*hsv_pkg::BYTE_W-1:0]       out_pprod
);

   localparam int unsigned FRAC_W = HUE_FRACTION_BITS + 6;
   localparam int unsigned SPAN   = 60 << HUE_FRACTION_BITS;
   localparam int unsigned BASE_W = hsv_pkg::QUOT_W + FRAC_W;
   localparam int unsigned P60_W  = hsv_pkg::DIV60_IN_W + hsv_pkg::RECIP60_W;
   localparam int unsigned P6_W   = hsv_pkg::QUOT_W + hsv_pkg::RECIP6_W;
   localparam logic [FRAC_W-1:0] SPAN_C = FRAC_W'(SPAN);

   logic [hsv_pkg::HUE_W-1:0]      hue_x;
   logic [P60_W-1:0]               p60_prod;
   logic [hsv_pkg::QUOT_W-1:0]     quot_a_in;
   logic [2*hsv_pkg::BYTE_W-1:0]   pprod_a_in;

   logic                           valid_a_ff;
   logic [hsv_pkg::QUOT_W-1:0]     quot_a_ff;
   logic [hsv_pkg::HUE_W-1:0]      hue_a_ff;
   logic [hsv_pkg::BYTE_W-1:0]     sat_a_ff;
   logic [hsv_pkg::BYTE_W-1:0]     val_a_ff;
   logic [2*hsv_pkg::BYTE_W-1:0]   pprod_a_ff;

   logic [BASE_W-1:0]              base_b;
   logic [BASE_W-1:0]              diff_b;
   logic [FRAC_W-1:0]              frac_b_in;
   logic [P6_W-1:0]                p6_prod;
   logic [hsv_pkg::Q6_W-1:0]       quot6_b_in;

   logic                           valid_b_ff;
   logic [hsv_pkg::QUOT_W-1:0]     quot_b_ff;
   logic [hsv_pkg::Q6_W-1:0]       quot6_b_ff;
   logic [FRAC_W-1:0]              frac_b_ff;
   logic [hsv_pkg::BYTE_W-1:0]     sat_b_ff;
   logic [hsv_pkg::BYTE_W-1:0]     val_b_ff;
   logic [2*hsv_pkg::BYTE_W-1:0]   pprod_b_ff;

   // The whole-degree hue divided by 60 is the hue shifted by two, divided by 15.
   assign hue_x      = in_payload.hue >> HUE_FRACTION_BITS;
   assign p60_prod   = hue_x[hsv_pkg::HUE_W-1:2] * hsv_pkg::RECIP60_MULT;
   assign quot_a_in  = p60_prod[hsv_pkg::RECIP60_SHIFT +: hsv_pkg::QUOT_W];
   assign pprod_a_in = in_payload.brightness * (8'd255 - in_payload.saturation);

   assign base_b     = quot_a_ff * SPAN_C;
   assign diff_b     = BASE_W'(hue_a_ff) - base_b;
   assign frac_b_in  = diff_b[FRAC_W-1:0];
   assign p6_prod    = quot_a_ff * hsv_pkg::RECIP6_MULT;
   assign quot6_b_in = p6_prod[hsv_pkg::RECIP6_SHIFT +: hsv_pkg::Q6_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_a_ff  <= quot_a_in;
         hue_a_ff   <= in_payload.hue;
         sat_a_ff   <= in_payload.saturation;
         val_a_ff   <= in_payload.brightness;
         pprod_a_ff <= pprod_a_in;
         quot_b_ff  <= quot_a_ff;
         quot6_b_ff <= quot6_b_in;
         frac_b_ff  <= frac_b_in;
         sat_b_ff   <= sat_a_ff;
         val_b_ff   <= val_a_ff;
         pprod_b_ff <= pprod_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_quot  = quot_b_ff;
   assign out_quot6 = quot6_b_ff;
   assign out_frac  = frac_b_ff;
   assign out_sat   = sat_b_ff;
   assign out_val   = val_b_ff;
   assign out_pprod = pprod_b_ff;

endmodule

/* hw/rtl/hsv_term_calc.sv */
// Three pipeline stages that form the sector and the p, q and t terms.
// The q and t quotients leave as reciprocal products; uses hsv_pkg.
`timescale 1ns / 1ps

module hsv_term_calc #(
   parameter int unsigned HUE_FRACTION_BITS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  logic [hsv_pkg::QUOT_W-1:0]         in_quot,
   input  logic [hsv_pkg::Q6_W-1:0]           in_quot6,
   input  logic [HUE_FRACTION_BITS+5:0]       in_frac,
   input  logic [hsv_pkg::BYTE_W-1:0]         in_sat,
   input  logic [hsv_pkg::BYTE_W-1:0]         in_val,
   input  logic [2*hsv_pkg::BYTE_W-1:0]       in_pprod,
   output logic                               out_valid,
   output hsv_pkg::sector_type                out_sector,
   output logic [hsv_pkg::BYTE_W-1:0]         out_val,
   output logic [hsv_pkg::BYTE_W-1:0]         out_pv,
   output logic [hsv_pkg::DIV_IN_W+hsv_pkg::RECIP3825_W-1:0] out_qprod,
   output logic [hsv_pkg::DIV_IN_W+hsv_pkg::RECIP3825_W-1:0] out_tprod
);

   localparam int unsigned FRAC_W = HUE_FRACTION_BITS + 6;
   localparam int unsigned FULL_W = FRAC_W + hsv_pkg::BYTE_W;
   localparam int unsigned NUM_W  = FULL_W + hsv_pkg::BYTE_W;
   localparam int unsigned SPAN   = 60 << HUE_FRACTION_BITS;
   localparam int unsigned FULL   = 255 * SPAN;
   localparam int unsigned RP_W   = hsv_pkg::DIV_IN_W + hsv_pkg::RECIP3825_W;
   localparam logic [FRAC_W-1:0] SPAN_C = FRAC_W'(SPAN);
   localparam logic [FULL_W-1:0] FULL_C = FULL_W'(FULL);

   logic [hsv_pkg::QUOT_W-1:0]     sec_diff;
   hsv_pkg::sector_type            sector_c_in;
   logic [2*hsv_pkg::BYTE_W:0]     pv_sum;
   logic [hsv_pkg::BYTE_W-1:0]     pv_c_in;
   logic [FULL_W-1:0]              sq_c_in;
   logic [FULL_W-1:0]              st_c_in;

   logic                           valid_c_ff;
   hsv_pkg::sector_type            sector_c_ff;
   logic [hsv_pkg::BYTE_W-1:0]     val_c_ff;
   logic [hsv_pkg::BYTE_W-1:0]     pv_c_ff;
   logic [FULL_W-1:0]              sq_c_ff;
   logic [FULL_W-1:0]              st_c_ff;

   logic [NUM_W-1:0]               numq_d_in;
   logic [NUM_W-1:0]               numt_d_in;

   logic                           valid_d_ff;
   hsv_pkg::sector_type            sector_d_ff;
   logic [hsv_pkg::BYTE_W-1:0]     val_d_ff;
   logic [hsv_pkg::BYTE_W-1:0]     pv_d_ff;
   logic [NUM_W-1:0]               numq_d_ff;
   logic [NUM_W-1:0]               numt_d_ff;

   logic [RP_W-1:0]                qprod_e_in;
   logic [RP_W-1:0]                tprod_e_in;

   logic                           valid_e_ff;
   hsv_pkg::sector_type            sector_e_ff;
   logic [hsv_pkg::BYTE_W-1:0]     val_e_ff;
   logic [hsv_pkg::BYTE_W-1:0]     pv_e_ff;
   logic [RP_W-1:0]                qprod_e_ff;
   logic [RP_W-1:0]                tprod_e_ff;

   assign sec_diff    = in_quot - hsv_pkg::QUOT_W'(in_quot6 * hsv_pkg::SECTOR_COUNT);
   assign sector_c_in = hsv_pkg::sector_type'(sec_diff[hsv_pkg::SECTOR_W-1:0]);

   // Exact floor division by 255 for values up to 65534, which covers any product of two bytes.
   assign pv_sum  = (2*hsv_pkg::BYTE_W+1)'(in_pprod)
                  + (2*hsv_pkg::BYTE_W+1)'(in_pprod >> hsv_pkg::BYTE_W)
                  + (2*hsv_pkg::BYTE_W+1)'(1);
   assign pv_c_in = pv_sum[hsv_pkg::BYTE_W +: hsv_pkg::BYTE_W];

   assign sq_c_in = in_sat * in_frac;
   assign st_c_in = in_sat * (SPAN_C - in_frac);

   assign numq_d_in = val_c_ff * (FULL_C - sq_c_ff);
   assign numt_d_in = val_c_ff * (FULL_C - st_c_ff);

   // Division by 255 * 60 << HUE_FRACTION_BITS: shift, then divide by 3825.
   assign qprod_e_in = numq_d_ff[HUE_FRACTION_BITS+2 +: hsv_pkg::DIV_IN_W]
                     * hsv_pkg::RECIP3825_MULT;
   assign tprod_e_in = numt_d_ff[HUE_FRACTION_BITS+2 +: hsv_pkg::DIV_IN_W]
                     * hsv_pkg::RECIP3825_MULT;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
         valid_e_ff <= 1'b0;
      end else if (advance) begin
         valid_c_ff <= in_valid;
         valid_d_ff <= valid_c_ff;
         valid_e_ff <= valid_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sector_c_ff <= sector_c_in;
         val_c_ff    <= in_val;
         pv_c_ff     <= pv_c_in;
         sq_c_ff     <= sq_c_in;
         st_c_ff     <= st_c_in;
         sector_d_ff <= sector_c_ff;
         val_d_ff    <= val_c_ff;
         pv_d_ff     <= pv_c_ff;
         numq_d_ff   <= numq_d_in;
         numt_d_ff   <= numt_d_in;
         sector_e_ff <= sector_d_ff;
         val_e_ff    <= val_d_ff;
         pv_e_ff     <= pv_d_ff;
         qprod_e_ff  <= qprod_e_in;
         tprod_e_ff  <= tprod_e_in;
      end
   end

   assign out_valid  = valid_e_ff;
   assign out_sector = sector_e_ff;
   assign out_val    = val_e_ff;
   assign out_pv     = pv_e_ff;
   assign out_qprod  = qprod_e_ff;
   assign out_tprod  = tprod_e_ff;

endmodule

/* hw/rtl/hsv_to_rgb_converter.sv */
// HSV to RGB converter, one color per request, six register stages deep.
// A request is accepted in every cycle in which the output register is empty or being
// drained, so the block sustains one request per clock while the output is not stalled;
// the request enters the hue split register at the accepting edge and then passes the
// fraction, products, numerators, reciprocal multiply and output registers in turn,
// stepping on only while the pipeline advances.
// Hue is in degrees with HUE_FRACTION_BITS fraction bits; hues at or above 360 wrap.
// Depends on hsv_pkg, hsv_hue_split and hsv_term_calc.
`timescale 1ns / 1ps

module hsv_to_rgb_converter #(
   parameter int unsigned HUE_FRACTION_BITS = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hsv_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hsv_pkg::rsp_payload_type rsp_payload
);

   localparam int unsigned FRAC_W = HUE_FRACTION_BITS + 6;
   localparam int unsigned RP_W   = hsv_pkg::DIV_IN_W + hsv_pkg::RECIP3825_W;

   logic                           advance;

   logic                           split_valid;
   logic [hsv_pkg::QUOT_W-1:0]     split_quot;
   logic [hsv_pkg::Q6_W-1:0]       split_quot6;
   logic [FRAC_W-1:0]              split_frac;
   logic [hsv_pkg::BYTE_W-1:0]     split_sat;
   logic [hsv_pkg::BYTE_W-1:0]     split_val;
   logic [2*hsv_pkg::BYTE_W-1:0]   split_pprod;

   logic                           term_valid;
   hsv_pkg::sector_type            term_sector;
   logic [hsv_pkg::BYTE_W-1:0]     term_val;
   logic [hsv_pkg::BYTE_W-1:0]     term_pv;
   logic [RP_W-1:0]                term_qprod;
   logic [RP_W-1:0]                term_tprod;

   logic [hsv_pkg::BYTE_W-1:0]     qv;
   logic [hsv_pkg::BYTE_W-1:0]     tv;
   hsv_pkg::rsp_payload_type       rsp_payload_in;
   hsv_pkg::rsp_payload_type       rsp_payload_ff;
   logic                           rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   hsv_hue_split #(
      .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
   ) u_hue_split (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .in_payload (req_payload),
      .out_valid  (split_valid),
      .out_quot   (split_quot),
      .out_quot6  (split_quot6),
      .out_frac   (split_frac),
      .out_sat    (split_sat),
      .out_val    (split_val),
      .out_pprod  (split_pprod)
   );

   hsv_term_calc #(
      .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
   ) u_term_calc (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (split_valid),
      .in_quot    (split_quot),
      .in_quot6   (split_quot6),
      .in_frac    (split_frac),
      .in_sat     (split_sat),
      .in_val     (split_val),
      .in_pprod   (split_pprod),
      .out_valid  (term_valid),
      .out_sector (term_sector),
      .out_val    (term_val),
      .out_pv     (term_pv),
      .out_qprod  (term_qprod),
      .out_tprod  (term_tprod)
   );

   assign qv = term_qprod[hsv_pkg::RECIP3825_SHIFT +: hsv_pkg::BYTE_W];
   assign tv = term_tprod[hsv_pkg::RECIP3825_SHIFT +: hsv_pkg::BYTE_W];

   always_comb begin
      case (term_sector)
         hsv_pkg::SEC_RED_YELLOW: begin
            rsp_payload_in = '{red: term_val, green: tv, blue: term_pv};
         end
         hsv_pkg::SEC_YELLOW_GREEN: begin
            rsp_payload_in = '{red: qv, green: term_val, blue: term_pv};
         end
         hsv_pkg::SEC_GREEN_CYAN: begin
            rsp_payload_in = '{red: term_pv, green: term_val, blue: tv};
         end
         hsv_pkg::SEC_CYAN_BLUE: begin
            rsp_payload_in = '{red: term_pv, green: qv, blue: term_val};
         end
         hsv_pkg::SEC_BLUE_MAGENTA: begin
            rsp_payload_in = '{red: tv, green: term_pv, blue: term_val};
         end
         default: begin
            rsp_payload_in = '{red: term_val, green: term_pv, blue: qv};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= term_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
